### rtl/redec_pkg.sv
package redec_pkg;

    // Timer value that marks a press or release interval as idle.
    localparam logic [13:0] IDLE_MARK      = 14'd10000;
    // Debounce counter stops counting here.
    localparam logic [2:0]  DEBOUNCE_LIMIT = 3'd5;
    // A press must last longer than this to count as a click.
    localparam logic [13:0] MIN_PRESS      = 14'd5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_SWITCH  = 2'd1,
        CMD_ENCODER = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        EV_ROTATION = 2'd0,
        EV_SINGLE   = 2'd1,
        EV_DOUBLE   = 2'd2,
        EV_LONG     = 2'd3
    } t_event;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACCEL_ENABLE        = 3'd0,
        CFG_ACCEL_MAX           = 3'd1,
        CFG_ACCEL_HOLD          = 3'd2,
        CFG_DOUBLE_CLICK_ENABLE = 3'd3,
        CFG_LONG_PRESS_TICKS    = 3'd4,
        CFG_DOUBLE_WINDOW_TICKS = 3'd5,
        CFG_DEBOUNCE_TICKS      = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic        accel_enable;
        logic [14:0] accel_max;
        logic [7:0]  accel_hold;
        logic        double_click_enable;
        logic [13:0] long_press_ticks;
        logic [13:0] double_window_ticks;
        logic [2:0]  debounce_ticks;
    } t_cfg;

    typedef struct packed {
        t_event             kind;
        logic signed [15:0] value;
        logic               last;
    } t_beat;

    typedef struct packed {
        logic [1:0] count;
        t_beat      first;
        t_beat      second;
    } t_results;

endpackage

### rtl/redec_in_if.sv
interface redec_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic       sw_level;
    logic       enc_a;
    logic       enc_b;

    modport source (output valid, output command, output sw_level, output enc_a,
                    output enc_b, input ready);
    modport sink   (input valid, input command, input sw_level, input enc_a,
                    input enc_b, output ready);
endinterface

### rtl/redec_out_if.sv
interface redec_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         event_kind;
    logic signed [15:0] rotation_value;
    logic               last;

    modport source (output valid, output event_kind, output rotation_value,
                    output last, input ready);
    modport sink   (input valid, input event_kind, input rotation_value,
                    input last, output ready);
endinterface

### rtl/redec_core.sv
module redec_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic [1:0]          i_cmd,
    input  logic                i_sw,
    input  logic                i_a,
    input  logic                i_b,
    input  redec_pkg::t_cfg     i_cfg,
    output redec_pkg::t_results o_res
);

    logic [2:0]  r_deb,    n_deb;
    logic        r_stable, n_stable;
    logic [13:0] r_press,  n_press;
    logic [13:0] r_rel,    n_rel;
    logic [7:0]  r_hold,   n_hold;
    logic [14:0] r_accel,  n_accel;
    logic [1:0]  r_first,  n_first;
    logic        r_mid,    n_mid;
    logic [1:0]  r_third,  n_third;

    logic               long_hit, single_hit, double_hit, step_hit;
    logic signed [15:0] step_value;
    logic [15:0]        mag;
    logic [13:0]        click_at;
    logic [1:0]         lv;
    logic [1:0]         key_count;
    redec_pkg::t_event  k0, k1;

    always_comb begin
        n_deb      = r_deb;
        n_stable   = r_stable;
        n_press    = r_press;
        n_rel      = r_rel;
        n_hold     = r_hold;
        n_accel    = r_accel;
        n_first    = r_first;
        n_mid      = r_mid;
        n_third    = r_third;
        long_hit   = 1'b0;
        single_hit = 1'b0;
        double_hit = 1'b0;
        step_hit   = 1'b0;
        step_value = '0;
        click_at   = i_cfg.double_click_enable ? i_cfg.double_window_ticks : 14'd1;
        lv         = {i_b, i_a};
        mag        = {1'b0, r_accel} + 16'd1;

        unique case (redec_pkg::t_cmd'(i_cmd))
            redec_pkg::CMD_TICK: begin
                // sample the switch once debounce time has run out
                if (r_deb < redec_pkg::DEBOUNCE_LIMIT) begin
                    n_deb = r_deb + 3'd1;
                    if (n_deb == i_cfg.debounce_ticks) begin
                        n_stable = i_sw;
                    end
                end
                if (!n_stable && n_press < redec_pkg::IDLE_MARK) begin
                    n_press = n_press + 14'd1;
                    if (n_press == i_cfg.long_press_ticks) begin
                        long_hit = 1'b1;
                    end
                end
                if (n_rel < redec_pkg::IDLE_MARK) begin
                    n_rel = n_rel + 14'd1;
                    if (n_rel == click_at) begin
                        n_rel      = redec_pkg::IDLE_MARK;
                        single_hit = 1'b1;
                    end
                end
                if (n_stable) begin
                    if (n_press > redec_pkg::MIN_PRESS && n_press < i_cfg.long_press_ticks) begin
                        if (n_rel > i_cfg.double_window_ticks) begin
                            n_rel = '0;
                        end else if (n_rel < i_cfg.double_window_ticks) begin
                            n_rel      = redec_pkg::IDLE_MARK;
                            double_hit = 1'b1;
                        end
                    end
                    n_press = '0;
                end
                if (r_hold != 8'd0) begin
                    n_hold = r_hold - 8'd1;
                    if (mag < {1'b0, i_cfg.accel_max}) begin
                        n_accel = r_accel + 15'd1;
                    end
                end else begin
                    n_accel = '0;
                end
            end
            redec_pkg::CMD_SWITCH: begin
                n_deb = '0;
            end
            redec_pkg::CMD_ENCODER: begin
                if ((lv == 2'd1 || lv == 2'd2) && n_first == 2'd0 && n_mid && n_third == 2'd0) begin
                    n_first = lv;
                end
                if (lv == 2'd0 && n_first != 2'd0 && n_mid && n_third == 2'd0) begin
                    n_mid = 1'b0;
                end
                if ((lv == 2'd1 || lv == 2'd2) && n_first != 2'd0 && !n_mid && n_third == 2'd0) begin
                    n_third = lv;
                end
                if (n_first == 2'd1 && !n_mid && n_third == 2'd2) begin
                    step_hit   = 1'b1;
                    step_value = -$signed(mag);
                end
                if (n_first == 2'd2 && !n_mid && n_third == 2'd1) begin
                    step_hit   = 1'b1;
                    step_value = $signed(mag);
                end
                if (step_hit || lv == 2'd3) begin
                    n_first = '0;
                    n_third = '0;
                    n_mid   = 1'b1;
                end
                if (step_hit && i_cfg.accel_enable) begin
                    n_hold = i_cfg.accel_hold;
                end
            end
            default: begin
            end
        endcase
    end

    // pack a rotation step, or else key events in order: long press, single click, double click
    always_comb begin
        key_count = 2'({1'b0, long_hit} + {1'b0, single_hit} + {1'b0, double_hit});
        k0 = long_hit ? redec_pkg::EV_LONG
           : (single_hit ? redec_pkg::EV_SINGLE : redec_pkg::EV_DOUBLE);
        k1 = (long_hit && single_hit) ? redec_pkg::EV_SINGLE : redec_pkg::EV_DOUBLE;
        if (step_hit) begin
            o_res.count  = 2'd1;
            o_res.first  = '{kind: redec_pkg::EV_ROTATION, value: step_value, last: 1'b1};
        end else begin
            o_res.count  = key_count;
            o_res.first  = '{kind: k0, value: 16'sd0, last: (key_count == 2'd1)};
        end
        o_res.second = '{kind: k1, value: 16'sd0, last: 1'b1};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deb    <= '0;
            r_stable <= 1'b1;
            r_press  <= redec_pkg::IDLE_MARK;
            r_rel    <= redec_pkg::IDLE_MARK;
            r_hold   <= '0;
            r_accel  <= '0;
            r_first  <= '0;
            r_mid    <= 1'b1;
            r_third  <= '0;
        end else if (i_fire) begin
            r_deb    <= n_deb;
            r_stable <= n_stable;
            r_press  <= n_press;
            r_rel    <= n_rel;
            r_hold   <= n_hold;
            r_accel  <= n_accel;
            r_first  <= n_first;
            r_mid    <= n_mid;
            r_third  <= n_third;
        end
    end

    a_mid_needs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_mid |-> r_first != 2'd0)
        else $error("decoder past first phase without a first level");

    a_third_needs_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_third != 2'd0 |-> !r_mid)
        else $error("decoder third phase set before middle phase");

endmodule

### rtl/rotary_encoder_button_decoder_unit.sv
// Results: the result beats of an accepted item are written to the registered result queue.
// Throughput: one item per cycle while the result queue has room for two beats; items that
// give two results are bound by the one-beat-per-cycle output.
// Result queue: four beats of registers; the input stays open while two slots are free.
// Reset (synchronous, active low): config to defaults, switch released, timers idle, queue empty.
module rotary_encoder_button_decoder_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    redec_in_if.sink                             i_in,
    redec_out_if.source                          o_out,
    input  logic                                 i_cfg_we,
    input  logic [redec_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [redec_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    redec_pkg::t_cfg     r_cfg;
    redec_pkg::t_results res;

    // result queue
    redec_pkg::t_beat r_fifo [4];
    logic [1:0]       r_wr, r_rd;
    logic [2:0]       r_count, n_count;

    logic fire;
    logic pop;
    logic [2:0] push;

    // hold the input until two queue slots are free
    assign i_in.ready = (r_count < 3'd3);
    assign fire       = i_in.valid && i_in.ready;
    assign pop        = o_out.valid && o_out.ready;
    assign push       = fire ? {1'b0, res.count} : 3'd0;
    assign n_count    = r_count + push - {2'b00, pop};

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.accel_enable        <= 1'b0;
            r_cfg.accel_max           <= '0;
            r_cfg.accel_hold          <= '0;
            r_cfg.double_click_enable <= 1'b1;
            r_cfg.long_press_ticks    <= 14'd400;
            r_cfg.double_window_ticks <= 14'd400;
            r_cfg.debounce_ticks      <= 3'd3;
        end else if (i_cfg_we) begin
            unique case (redec_pkg::t_cfg_idx'(i_cfg_idx))
                redec_pkg::CFG_ACCEL_ENABLE:        r_cfg.accel_enable        <= i_cfg_data[0];
                redec_pkg::CFG_ACCEL_MAX:           r_cfg.accel_max           <= i_cfg_data[14:0];
                redec_pkg::CFG_ACCEL_HOLD:          r_cfg.accel_hold          <= i_cfg_data[7:0];
                redec_pkg::CFG_DOUBLE_CLICK_ENABLE: r_cfg.double_click_enable <= i_cfg_data[0];
                redec_pkg::CFG_LONG_PRESS_TICKS:    r_cfg.long_press_ticks    <= i_cfg_data[13:0];
                redec_pkg::CFG_DOUBLE_WINDOW_TICKS: r_cfg.double_window_ticks <= i_cfg_data[13:0];
                redec_pkg::CFG_DEBOUNCE_TICKS:      r_cfg.debounce_ticks      <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    // decode the beat against the current state; state advances on accept only
    redec_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_cmd   (i_in.command),
        .i_sw    (i_in.sw_level),
        .i_a     (i_in.enc_a),
        .i_b     (i_in.enc_b),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    // write up to two result beats per accepted item
    always_ff @(posedge i_clk) begin
        if (fire && res.count != 2'd0) begin
            r_fifo[r_wr] <= res.first;
        end
        if (fire && res.count == 2'd2) begin
            r_fifo[r_wr + 2'd1] <= res.second;
        end
    end

    // advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + push[1:0];
            r_rd    <= r_rd + {1'b0, pop};
            r_count <= n_count;
        end
    end

    // present the head of the queue
    assign o_out.valid          = (r_count != 3'd0);
    assign o_out.event_kind     = r_fifo[r_rd].kind;
    assign o_out.rotation_value = r_fifo[r_rd].value;
    assign o_out.last           = r_fifo[r_rd].last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4)
        else $error("result queue overflow");

    a_pair_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && res.count == 2'd2 && !pop) |=> r_count == $past(r_count) + 3'd2)
        else $error("pair of result beats not both queued");

    a_partner_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.last) |-> r_count >= 3'd2)
        else $error("non-final beat shown without its partner queued");

    a_key_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.event_kind != redec_pkg::EV_ROTATION)
            |-> o_out.rotation_value == 16'sd0)
        else $error("key event carries a nonzero step value");

endmodule
